FILE: rtl/core/bdr_pkg.sv
// shared types, constants and constant tables for the bayer dither block
`timescale 1ns / 1ps
`default_nettype none

package bdr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int PIPE_DEPTH     = 5;
    localparam int CFG_AW         = 2;
    localparam int CFG_DW         = 9;

    localparam int Q16_ONE  = 65536;
    localparam int Q16_HALF = 32768;
    localparam int TMAX2    = 3;
    localparam int TMAX4    = 15;
    localparam int TMAX8    = 63;
    localparam int NORM_MAX5 = 31;
    localparam int NORM_MAX6 = 63;

    typedef enum logic [CFG_AW-1:0] {
        REG_DITHER_MODE  = 2'd0,
        REG_QUANT_LEVELS = 2'd1,
        REG_BLEND_WEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_BAYER2 = 2'd0,
        MODE_BAYER4 = 2'd1,
        MODE_BAYER8 = 2'd2,
        MODE_FLAT   = 2'd3
    } dither_mode_t;

    localparam dither_mode_t DITHER_MODE_RST  = MODE_BAYER8;
    localparam logic [4:0]   QUANT_LEVELS_RST = 5'd3;
    localparam logic [4:0]   QUANT_MIN        = 5'd2;
    localparam logic [4:0]   QUANT_MAX        = 5'd16;
    localparam logic [8:0]   BLEND_WEIGHT_RST = 9'd256;
    localparam logic [8:0]   WEIGHT_MAX       = 9'd256;

    typedef logic signed [12:0] off_t;
    typedef logic [16:0]        q16_t;

    typedef struct packed {
        logic         adv;
        dither_mode_t mode;
        logic [3:0]   lm1;
        logic [8:0]   weight;
    } bdr_ctrl_t;

    typedef logic [63:0][12:0]  off_tab_t;
    typedef logic [63:0][16:0]  norm_tab_t;
    typedef logic [255:0][5:0]  rescale_tab_t;

    localparam logic [5:0] BAYER2 [4] = '{6'd0, 6'd2, 6'd3, 6'd1};

    localparam logic [5:0] BAYER4 [16] = '{
        6'd0,  6'd8,  6'd2,  6'd10,
        6'd12, 6'd4,  6'd14, 6'd6,
        6'd3,  6'd11, 6'd1,  6'd9,
        6'd15, 6'd7,  6'd13, 6'd5
    };

    localparam logic [5:0] BAYER8 [64] = '{
        6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
        6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
        6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
        6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
        6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
        6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
        6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
        6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
    };

    // offset (thr - 0.5) / 10 in q16, indexed by {row[2:0], col[2:0]}
    function automatic off_tab_t build_off_pos(input int mode);
        off_tab_t    tab;
        int          t;
        int          thr;
        int          off;
        logic [5:0]  p;
        tab = '0;
        for (int i = 0; i < 64; i++)
        begin
            p = 6'(i);
            case (mode)
                0:
                begin
                    t   = int'(BAYER2[{p[3], p[0]}]);
                    thr = (t << 16) / TMAX2;
                end
                1:
                begin
                    t   = int'(BAYER4[{p[4:3], p[1:0]}]);
                    thr = (t << 16) / TMAX4;
                end
                2:
                begin
                    t   = int'(BAYER8[p]);
                    thr = (t << 16) / TMAX8;
                end
                default:
                begin
                    thr = 0;
                end
            endcase
            off    = (thr - Q16_HALF) / 10;
            tab[i] = off[12:0];
        end
        return tab;
    endfunction

    // component normalised to q16, floored
    function automatic norm_tab_t build_norm(input int cw);
        norm_tab_t tab;
        int        x;
        tab = '0;
        for (int v = 0; v < 64; v++)
        begin
            if (cw == 5)
                x = (v << 16) / NORM_MAX5;
            else
                x = (v << 16) / NORM_MAX6;
            tab[v] = 17'(x);
        end
        return tab;
    endfunction

    // floor(q * m / lm1), indexed by {lm1, q}
    function automatic rescale_tab_t build_rescale(input int m);
        rescale_tab_t tab;
        int           d;
        tab = '0;
        for (int l = 0; l < 16; l++)
        begin
            for (int q = 0; q < 16; q++)
            begin
                d = 0;
                if (l != 0)
                begin
                    for (int k = 0; k < 64; k++)
                    begin
                        if (k * l <= q * m)
                            d = k;
                    end
                end
                tab[l * 16 + q] = 6'(d);
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bdr_thresh.sv
// threshold offset lookup from the pixel position, first pipeline stage
`timescale 1ns / 1ps
`default_nettype none

module bdr_thresh #(
    parameter int COORD_BITS = bdr_pkg::COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire bdr_pkg::bdr_ctrl_t    ctrl,
    input  wire logic [COORD_BITS-1:0] col,
    input  wire logic [COORD_BITS-1:0] line,
    output bdr_pkg::off_t              off
);
    import bdr_pkg::*;

    localparam off_tab_t OFF2    = build_off_pos(0);
    localparam off_tab_t OFF4    = build_off_pos(1);
    localparam off_tab_t OFF8    = build_off_pos(2);
    localparam off_tab_t OFFFLAT = build_off_pos(3);

    logic [5:0] pos;
    off_t       off_next;
    off_t       off_reg;

    assign pos = {line[2:0], col[2:0]};

    always_comb
    begin
        case (ctrl.mode)
            MODE_BAYER2: off_next = OFF2[pos];
            MODE_BAYER4: off_next = OFF4[pos];
            MODE_BAYER8: off_next = OFF8[pos];
            default:     off_next = OFFFLAT[pos];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
            off_reg <= off_next;
    end

    assign off = off_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bdr_comp.sv
// per-component datapath: normalise, offset and clamp, quantise, rescale, blend
`timescale 1ns / 1ps
`default_nettype none

module bdr_comp #(
    parameter int CW = 5
) (
    input  wire logic               clk,
    input  wire bdr_pkg::bdr_ctrl_t ctrl,
    input  wire logic [CW-1:0]      v,
    input  wire bdr_pkg::off_t      off,
    output logic [CW-1:0]           res
);
    import bdr_pkg::*;

    localparam int           MAXV = (1 << CW) - 1;
    localparam norm_tab_t    NORM = build_norm(CW);
    localparam rescale_tab_t RESC = build_rescale(MAXV);

    logic [CW-1:0]      v1_reg;
    logic [CW-1:0]      v2_reg;
    logic [CW-1:0]      v3_reg;
    logic [CW-1:0]      v4_reg;
    q16_t               norm1_reg;
    logic signed [18:0] sum2;
    q16_t               n2_next;
    q16_t               n2_reg;
    logic [20:0]        prod3;
    logic [3:0]         q3_next;
    logic [3:0]         q3_reg;
    logic [5:0]         resc_word;
    logic [CW-1:0]      d4_next;
    logic [CW-1:0]      d4_reg;
    logic [14:0]        blend5;
    logic [CW-1:0]      res_next;
    logic [CW-1:0]      res_reg;

    // offset and clamp to [0, 1]
    always_comb
    begin
        sum2 = $signed({2'b00, norm1_reg}) + $signed({{6{off[12]}}, off});
        if (sum2 < 19'sd0)
            n2_next = '0;
        else if (sum2 > 19'sd65536)
            n2_next = 17'(Q16_ONE);
        else
            n2_next = sum2[16:0];
    end

    // round to the level grid
    assign prod3   = 21'(n2_reg) * 21'(ctrl.lm1) + 21'(Q16_HALF);
    assign q3_next = prod3[19:16];

    assign resc_word = RESC[{ctrl.lm1, q3_reg}];
    assign d4_next   = resc_word[CW-1:0];

    assign blend5   = 15'(d4_reg) * 15'(ctrl.weight)
                    + 15'(v4_reg) * (15'(WEIGHT_MAX) - 15'(ctrl.weight));
    assign res_next = blend5[CW+7:8];

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            v1_reg    <= v;
            norm1_reg <= NORM[6'(v)];
            v2_reg    <= v1_reg;
            n2_reg    <= n2_next;
            v3_reg    <= v2_reg;
            q3_reg    <= q3_next;
            v4_reg    <= v3_reg;
            d4_reg    <= d4_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bayer_dither_rgb565.sv
// top level of the bayer ordered dither for rgb565 pixels
`timescale 1ns / 1ps
`default_nettype none

// Ordered dither of an RGB565 pixel stream. One pixel is taken per clock while
// in_ready is high, and each result passes through a five-stage pipeline
// (offset lookup and normalise, offset and clamp, quantise multiply, rescale lookup,
// blend multiply) whose last stage is the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so in_ready
// follows out_ready in the same cycle while the output is full. The three
// configuration registers are written through cfg_we / cfg_addr / cfg_data at any
// edge with no wait; out-of-range values saturate and unknown indexes are ignored.
// Write them only while no pixels are in flight. No state links successive pixels.
module bayer_dither_rgb565 #(
    parameter int COORD_BITS = bdr_pkg::COORD_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [15:0]                pixel_in,
    input  wire logic [COORD_BITS-1:0]      col,
    input  wire logic [COORD_BITS-1:0]      line,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [15:0]                     pixel_out,
    input  wire logic                       cfg_we,
    input  wire logic [bdr_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [bdr_pkg::CFG_DW-1:0] cfg_data
);
    import bdr_pkg::*;

    dither_mode_t          dither_mode_reg;
    dither_mode_t          dither_mode_next;
    logic [4:0]            quant_levels_reg;
    logic [4:0]            quant_levels_next;
    logic [8:0]            blend_weight_reg;
    logic [8:0]            blend_weight_next;
    logic [PIPE_DEPTH-1:0] stg_valid_reg;
    logic [PIPE_DEPTH-1:0] stg_valid_next;
    logic                  adv;
    bdr_ctrl_t             ctrl;
    off_t                  off;
    logic [4:0]            red;
    logic [5:0]            green;
    logic [4:0]            blue;

    // register writes, saturated
    always_comb
    begin
        dither_mode_next  = dither_mode_reg;
        quant_levels_next = quant_levels_reg;
        blend_weight_next = blend_weight_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_DITHER_MODE:
                begin
                    dither_mode_next = dither_mode_t'(cfg_data[1:0]);
                end
                REG_QUANT_LEVELS:
                begin
                    if (cfg_data[4:0] < QUANT_MIN)
                        quant_levels_next = QUANT_MIN;
                    else if (cfg_data[4:0] > QUANT_MAX)
                        quant_levels_next = QUANT_MAX;
                    else
                        quant_levels_next = cfg_data[4:0];
                end
                REG_BLEND_WEIGHT:
                begin
                    if (cfg_data[8:0] > WEIGHT_MAX)
                        blend_weight_next = WEIGHT_MAX;
                    else
                        blend_weight_next = cfg_data[8:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // pipeline moves as a whole when the output register can take a transfer
    assign adv      = !stg_valid_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        if (adv)
            stg_valid_next = {stg_valid_reg[PIPE_DEPTH-2:0], in_valid};
        else
            stg_valid_next = stg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_mode_reg  <= DITHER_MODE_RST;
            quant_levels_reg <= QUANT_LEVELS_RST;
            blend_weight_reg <= BLEND_WEIGHT_RST;
            stg_valid_reg    <= '0;
        end
        else
        begin
            dither_mode_reg  <= dither_mode_next;
            quant_levels_reg <= quant_levels_next;
            blend_weight_reg <= blend_weight_next;
            stg_valid_reg    <= stg_valid_next;
        end
    end

    assign ctrl.adv    = adv;
    assign ctrl.mode   = dither_mode_reg;
    assign ctrl.lm1    = 4'(quant_levels_reg - 5'd1);
    assign ctrl.weight = blend_weight_reg;

    bdr_thresh #(
        .COORD_BITS (COORD_BITS)
    ) u_thresh (
        .clk  (clk),
        .ctrl (ctrl),
        .col  (col),
        .line (line),
        .off  (off)
    );

    bdr_comp #(
        .CW (5)
    ) u_comp_r (
        .clk  (clk),
        .ctrl (ctrl),
        .v    (pixel_in[15:11]),
        .off  (off),
        .res  (red)
    );

    bdr_comp #(
        .CW (6)
    ) u_comp_g (
        .clk  (clk),
        .ctrl (ctrl),
        .v    (pixel_in[10:5]),
        .off  (off),
        .res  (green)
    );

    bdr_comp #(
        .CW (5)
    ) u_comp_b (
        .clk  (clk),
        .ctrl (ctrl),
        .v    (pixel_in[4:0]),
        .off  (off),
        .res  (blue)
    );

    assign out_valid = stg_valid_reg[PIPE_DEPTH-1];
    assign pixel_out = {red, green, blue};

endmodule

`default_nettype wire

FILE: rtl/core/bdr_checker.sv
// port-level checks for the bayer dither block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bdr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] pixel_out
);

    // a stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out))
        else $error("result changed while stalled");

    // input side is only held off by a full, stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output backpressure");

    // with out_ready high and no reset throughout, out_valid follows the transfers through the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
        && $past(out_ready, 4) && $past(out_ready, 5)
        && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
        && $past(rst_n, 4) && $past(rst_n, 5)
        |-> out_valid == $past(in_valid && in_ready, 5))
        else $error("result count does not match transfers");

endmodule

bind bayer_dither_rgb565 bdr_checker u_bdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out)
);

`default_nettype wire
